// ===== src/sld_pkg.sv =====
package sld_pkg;

  localparam int SYNC_BYTES_DEF   = 8;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int LENGTH_BITS_DEF  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int POS_W       = 16;
  localparam int MAX_W       = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic             REG_MAX_LEN   = 1'b0;
  localparam logic [MAX_W-1:0] MAX_LEN_RESET = 16'd1024;

  typedef struct packed {
    logic       burst;
    logic [7:0] data;
    logic       fend;
    logic       ferr;
  } sld_entry_t;

  function automatic logic [7:0] sync_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = 8'h58;
      3'd1: b = 8'h47;
      3'd2: b = 8'h48;
      3'd3: b = 8'h4A;
      3'd4: b = 8'h78;
      3'd5: b = 8'h67;
      3'd6: b = 8'h68;
      3'd7: b = 8'h6A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // True when the last k-1 matched bytes of an m-byte match equal the first k-1 sync bytes.
  function automatic logic sync_border(input logic [4:0] m, input logic [4:0] k);
    logic ok;
    int   s;
    ok = 1'b1;
    s  = 0;
    for (int j = 0; j < 15; j++) begin
      if (j + 1 < int'(k)) begin
        s = int'(m) - int'(k) + 1 + j;
        if (sync_byte(3'(s)) != sync_byte(3'(j))) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== src/signature_length_deframer.sv =====
// Sync-word / length-field deframer.
// Input channel (in_valid/in_ready/in_byte): one raw link byte per word.
// Output channel (out_valid/out_ready/out_*): framed bytes with frame_start,
// frame_end, frame_error and burst_last flags.
// Configuration: APB register 0 at address 0 holds max_frame_length (reset 1024).
// Outside a frame, bytes are searched for the sync word and dropped. The byte
// that completes the sync word produces SYNC_BYTES output words; every byte
// inside a frame produces exactly one output word.
// Throughput: one input word per cycle inside a frame while the queue has space. A
// sync burst occupies the output for SYNC_BYTES words; a 4-entry queue between the
// parser and the output stage takes the header bytes that follow, and in_ready drops
// only when that queue is full.
// Path: an accepted input word is written into the queue at the accepting edge and
// is then loaded into the output register.
// Stall: while out_ready is low the output word holds, the queue fills, and
// in_ready then falls until space frees.
// Reset (synchronous, rst_n low): search state, frame state, queue and output
// valid are cleared; max_frame_length returns to 1024.
module signature_length_deframer #(
  parameter int SYNC_BYTES   = sld_pkg::SYNC_BYTES_DEF,
  parameter int HEADER_BYTES = sld_pkg::HEADER_BYTES_DEF,
  parameter int LENGTH_BITS  = sld_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_frame_start,
  output logic                           out_frame_end,
  output logic                           out_frame_error,
  output logic                           out_burst_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sld_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sld_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sld_pkg::*;

  logic [MAX_W-1:0] max_len_r, max_len_nxt;
  logic             cfg_wr;
  logic             q_full, push, head_valid, pop;
  sld_entry_t       push_entry, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);
  assign prdata = (paddr[2] == REG_MAX_LEN) ? CFG_DATA_W'(max_len_r) : '0;

  always_comb begin
    max_len_nxt = cfg_wr ? pwdata[MAX_W-1:0] : max_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  sld_front #(
    .SYNC_BYTES  (SYNC_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .max_len   (max_len_r),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  sld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  sld_back #(
    .SYNC_BYTES  (SYNC_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_start(out_frame_start),
    .out_frame_end  (out_frame_end),
    .out_frame_error(out_frame_error),
    .out_burst_last (out_burst_last)
  );

endmodule

// ===== src/sld_front.sv =====
module sld_front #(
  parameter int SYNC_BYTES   = sld_pkg::SYNC_BYTES_DEF,
  parameter int HEADER_BYTES = sld_pkg::HEADER_BYTES_DEF,
  parameter int LENGTH_BITS  = sld_pkg::LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic [sld_pkg::MAX_W-1:0] max_len,
  input  logic                     q_full,
  output logic                     push,
  output sld_pkg::sld_entry_t      push_entry
);
  import sld_pkg::*;

  localparam int MW   = $clog2(SYNC_BYTES + 1);
  localparam int AW   = LENGTH_BITS + 1;
  localparam int CMPW = (AW > POS_W + 1) ? AW : POS_W + 1;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_MINUS  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [MW-1:0]    match_r, match_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [MW-1:0]    new_m;
  logic             accept;
  logic             digit;
  logic [3:0]       dval;
  logic [AW+3:0]    prod;
  logic [AW-1:0]    acc_step;
  logic [1:0]       ph_p;
  logic             neg_p;
  logic [AW-1:0]    acc_p;
  logic             fend, ferr;
  logic [CMPW-1:0]  pos_inc_w;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    new_m = '0;
    for (int k = 1; k <= SYNC_BYTES; k++) begin
      if ((5'(k) <= 5'(match_r) + 5'd1) && sync_border(5'(match_r), 5'(k)) &&
          (in_byte == sync_byte(3'(k - 1)))) new_m = MW'(k);
    end
  end

  assign digit    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign dval     = 4'(in_byte - 8'h30);
  assign prod     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (AW+4)'(dval);
  assign acc_step = (|prod[AW+3:AW]) ? '1 : prod[AW-1:0];
  assign pos_inc_w = CMPW'(pos_r) + CMPW'(1);

  always_comb begin
    ph_p  = phase_r;
    neg_p = neg_r;
    acc_p = acc_r;
    unique case (phase_r)
      PH_SKIP: begin
        if (digit) begin
          acc_p = AW'(dval);
          ph_p  = PH_DIGITS;
        end else if (in_byte == 8'h2D) begin
          neg_p = 1'b1;
          ph_p  = PH_MINUS;
        end else if (in_byte == 8'h00) begin
          ph_p = PH_DONE;
        end
      end
      PH_MINUS: begin
        if (digit) begin
          acc_p = AW'(dval);
          ph_p  = PH_DIGITS;
        end else begin
          ph_p = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit) acc_p = acc_step;
        else ph_p = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    fend = 1'b0;
    ferr = 1'b0;
    if (pos_r < POS_W'(HEADER_BYTES)) begin
      if (pos_r == POS_W'(HEADER_BYTES - 1)) begin
        if (neg_p || (acc_p < AW'(HEADER_BYTES)) || (CMPW'(acc_p) > CMPW'(max_len))) begin
          ferr = 1'b1;
        end else if (acc_p == AW'(HEADER_BYTES)) begin
          fend = 1'b1;
        end
      end
    end else if (pos_inc_w >= CMPW'(acc_r)) begin
      fend = 1'b1;
    end
  end

  always_comb begin
    match_nxt    = match_r;
    in_frame_nxt = in_frame_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    push         = 1'b0;
    push_entry   = '{burst: 1'b0, data: in_byte, fend: fend, ferr: ferr};
    if (accept) begin
      if (!in_frame_r) begin
        if (new_m != MW'(SYNC_BYTES)) begin
          match_nxt = new_m;
        end else begin
          match_nxt        = '0;
          push             = 1'b1;
          push_entry.burst = 1'b1;
          push_entry.fend  = 1'b0;
          push_entry.ferr  = 1'b0;
          phase_nxt        = PH_SKIP;
          neg_nxt          = 1'b0;
          acc_nxt          = '0;
          in_frame_nxt     = (SYNC_BYTES < HEADER_BYTES);
          pos_nxt          = (SYNC_BYTES < HEADER_BYTES) ? POS_W'(SYNC_BYTES) : '0;
        end
      end else begin
        push = 1'b1;
        if (fend || ferr) begin
          in_frame_nxt = 1'b0;
          phase_nxt    = PH_SKIP;
          neg_nxt      = 1'b0;
          acc_nxt      = '0;
          pos_nxt      = '0;
          match_nxt    = '0;
        end else begin
          phase_nxt = ph_p;
          neg_nxt   = neg_p;
          acc_nxt   = acc_p;
          pos_nxt   = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= '0;
      in_frame_r <= 1'b0;
      phase_r    <= PH_SKIP;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      pos_r      <= '0;
    end else begin
      match_r    <= match_nxt;
      in_frame_r <= in_frame_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

// ===== src/sld_queue.sv =====
module sld_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sld_pkg::sld_entry_t push_entry,
  output logic                full,
  output logic                head_valid,
  output sld_pkg::sld_entry_t head,
  input  logic                pop
);
  import sld_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sld_entry_t    slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/sld_back.sv =====
module sld_back #(
  parameter int SYNC_BYTES   = sld_pkg::SYNC_BYTES_DEF,
  parameter int HEADER_BYTES = sld_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  sld_pkg::sld_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_frame_start,
  output logic                out_frame_end,
  output logic                out_frame_error,
  output logic                out_burst_last
);
  import sld_pkg::*;

  localparam int IW = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          start_r, start_nxt;
  logic          end_r, end_nxt;
  logic          err_r, err_nxt;
  logic          last_r, last_nxt;
  logic          load, idx_last;

  assign load     = head_valid && (!valid_r || out_ready);
  assign idx_last = (idx_r == IW'(SYNC_BYTES - 1));

  always_comb begin
    idx_nxt   = idx_r;
    byte_nxt  = byte_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    valid_nxt = out_ready ? 1'b0 : valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.burst) begin
        byte_nxt  = sync_byte(3'(idx_r));
        start_nxt = (idx_r == '0);
        end_nxt   = 1'b0;
        err_nxt   = idx_last && (SYNC_BYTES >= HEADER_BYTES);
        last_nxt  = idx_last;
        pop       = idx_last;
        idx_nxt   = idx_last ? '0 : idx_r + IW'(1);
      end else begin
        byte_nxt  = head.data;
        start_nxt = 1'b0;
        end_nxt   = head.fend;
        err_nxt   = head.ferr;
        last_nxt  = 1'b1;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    err_r   <= err_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_frame_start = start_r;
  assign out_frame_end   = end_r;
  assign out_frame_error = err_r;
  assign out_burst_last  = last_r;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sld_pkg::*;

  localparam int SYNC_LEN = SYNC_BYTES_DEF;
  localparam int HDR_LEN = HEADER_BYTES_DEF;
  localparam int HDR_TAIL = HDR_LEN - SYNC_LEN;
  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam int DRAIN = 8;
  localparam int STALL_LIMIT = 500;
  localparam int N_CASES = 12;
  localparam logic [63:0] SYNC_WORD = "XGHJxghj";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam int unsigned ACC_SAT_U = (1 << (LEN_W + 1)) - 1;

  typedef logic [LEN_W:0] acc_t;
  localparam acc_t LEN_SAT = acc_t'(ACC_SAT_U);

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} len_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       eof;
    logic       abort;
    logic       last;
  } frame_word_t;

  typedef struct packed {
    logic [63:0]  lead;
    logic [127:0] hdr;
    logic         typed;
    logic         t_eof;
    logic         t_abort;
  } hdr_case_t;

  localparam hdr_case_t HDR_CASES [N_CASES] = '{
    '{"XGHXGHJx", "LEN=0024;.......", 1'b1, 1'b1, 1'b0},
    '{{8'hFF, "Jxghj", 8'h00, 8'h01}, "len:30 body next", 1'b0, 1'b0, 1'b0},
    '{"XGHJxghX", "size=-30 .......", 1'b1, 1'b0, 1'b1},
    '{{8'h00, 8'hFF, "XGHJxg"}, "no length field!", 1'b1, 1'b0, 1'b1},
    '{"--0123-9", {"ab", 8'h00, "1234567890123"}, 1'b1, 1'b0, 1'b1},
    '{"XGHJxghX", "9999999999999999", 1'b1, 1'b0, 1'b1},
    '{"abcdefgh", "#23#############", 1'b1, 1'b0, 1'b1},
    '{{8{8'hFF}}, "1025 too long...", 1'b1, 1'b0, 1'b1},
    '{{8{8'h00}}, "40 fits 16 more.", 1'b0, 1'b0, 1'b0},
    '{"XXXXXXXX", {8'hFF, "-x", 8'hFF, "77777777777?"}, 1'b1, 1'b0, 1'b1},
    '{"jhgxJHGX", "  12a34.........", 1'b1, 1'b0, 1'b1},
    '{"XGHJXGHJ", "+025xxxxxxxxxxxx", 1'b0, 1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  out_frame_start;
  logic                  out_frame_end;
  logic                  out_frame_error;
  logic                  out_burst_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          hunt_cnt;
  bit          framing;
  len_phase_t  len_phase;
  bit          neg_seen;
  acc_t        len_acc;
  logic [15:0] frame_pos;
  logic [MAX_W-1:0] max_len;

  frame_word_t pending_words [$];
  bit          hdr_check_armed;
  bit          hdr_check_eof;
  bit          hdr_check_abort;
  bit          idling_on;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_in = 0;
  int unsigned busy_bytes = 0;
  int unsigned words_seen = 0;
  int unsigned frames_done = 0;
  int unsigned frames_aborted = 0;

  signature_length_deframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_frame_error (out_frame_error),
    .out_burst_last  (out_burst_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] sync_at(int i);
    return SYNC_WORD[8 * (7 - (i % 8)) +: 8];
  endfunction

  function automatic logic [7:0] pick_filler();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS);
    return c;
  endfunction

  function void clear_frame();
    framing = 1'b0;
    len_phase = PH_SKIP;
    neg_seen = 1'b0;
    len_acc = '0;
    frame_pos = '0;
  endfunction

  function void predict_byte(logic [7:0] b);
    int          m;
    bit          ok;
    logic [15:0] pos;
    frame_word_t w;
    logic        fin;
    logic        bad;
    logic        is_digit;
    logic [3:0]  d;
    int unsigned acc;
    bytes_in++;
    if (!framing) begin
      m = 0;
      if (hunt_cnt < SYNC_LEN && sync_at(hunt_cnt) == b) begin
        m = hunt_cnt + 1;
      end else begin
        for (int k = hunt_cnt; k >= 1 && m == 0; k--) begin
          ok = (sync_at(k - 1) == b);
          for (int j = 0; ok && j + 1 < k; j++)
            if (sync_at(j) != sync_at(hunt_cnt - k + 1 + j)) ok = 1'b0;
          if (ok) m = k;
        end
      end
      if (m < SYNC_LEN) begin
        hunt_cnt = m;
        return;
      end
      hunt_cnt = 0;
      for (int i = 0; i < SYNC_LEN; i++) begin
        w.data = sync_at(i);
        w.sof = (i == 0);
        w.eof = 1'b0;
        w.abort = (i == SYNC_LEN - 1) && (SYNC_LEN >= HDR_LEN);
        w.last = (i == SYNC_LEN - 1);
        pending_words.push_back(w);
      end
      clear_frame();
      if (SYNC_LEN < HDR_LEN) begin
        framing = 1'b1;
        frame_pos = 16'(SYNC_LEN);
      end
      busy_bytes++;
      return;
    end
    pos = frame_pos;
    fin = 1'b0;
    bad = 1'b0;
    if (pos < HDR_LEN) begin
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      d = 4'(b - CH_ZERO);
      acc = len_acc;
      case (len_phase)
        PH_SKIP: begin
          if (is_digit) begin
            len_acc = acc_t'(d);
            len_phase = PH_DIGITS;
          end else if (b == CH_MINUS) begin
            neg_seen = 1'b1;
            len_phase = PH_SIGN;
          end else if (b == CH_NUL) begin
            len_phase = PH_DONE;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            len_acc = acc_t'(d);
            len_phase = PH_DIGITS;
          end else begin
            len_phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (!is_digit) len_phase = PH_DONE;
          else if (acc > (ACC_SAT_U - d) / 10) len_acc = LEN_SAT;
          else len_acc = acc_t'(acc * 10 + d);
        end
        default: ;
      endcase
      if (int'(pos) + 1 == HDR_LEN) begin
        if (neg_seen || len_acc < HDR_LEN || len_acc > max_len) bad = 1'b1;
        else if (len_acc == HDR_LEN) fin = 1'b1;
      end
    end else if (int'(pos) + 1 >= int'(len_acc)) begin
      fin = 1'b1;
    end
    w = '{data: b, sof: 1'b0, eof: fin, abort: bad, last: 1'b1};
    if (hdr_check_armed) begin
      w.eof = hdr_check_eof;
      w.abort = hdr_check_abort;
      hdr_check_armed = 1'b0;
    end
    pending_words.push_back(w);
    busy_bytes++;
    if (fin) frames_done++;
    if (bad) frames_aborted++;
    if (fin || bad) begin
      clear_frame();
      hunt_cnt = 0;
    end else begin
      frame_pos = pos + 16'd1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_word_t exp_w;
    if (rst_n) begin
      if (in_valid && in_ready) predict_byte(in_byte);
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("out_byte %h arrived with no word pending", out_byte);
          mismatches++;
        end else begin
          exp_w = pending_words.pop_front();
          words_seen++;
          if (out_byte !== exp_w.data) begin
            $error("out_byte: expected %h, got %h", exp_w.data, out_byte);
            mismatches++;
          end
          if (out_frame_start !== exp_w.sof) begin
            $error("frame_start: expected %b, got %b", exp_w.sof, out_frame_start);
            mismatches++;
          end
          if (out_frame_end !== exp_w.eof) begin
            $error("frame_end: expected %b, got %b", exp_w.eof, out_frame_end);
            mismatches++;
          end
          if (out_frame_error !== exp_w.abort) begin
            $error("frame_error: expected %b, got %b", exp_w.abort, out_frame_error);
            mismatches++;
          end
          if (out_burst_last !== exp_w.last) begin
            $error("burst_last: expected %b, got %b", exp_w.last, out_burst_last);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL signature_length_deframer");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hold the word until accepted
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_max_len(input logic [MAX_W-1:0] v);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(REG_MAX_LEN));
    pwdata <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_len = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random_frame();
    logic [7:0] h [HDR_TAIL];
    int         n;
    int         bad_pos;
    int         mode;
    int         len;
    int         lim;
    int         p;
    string      digits;
    n = $urandom_range(0, 5);
    repeat (n)
      send_byte(($urandom_range(0, 1) == 1) ? sync_at($urandom_range(0, 7)) : 8'($urandom));
    bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SYNC_LEN - 1) : -1;
    for (int i = 0; i < SYNC_LEN; i++)
      send_byte((i == bad_pos) ? 8'($urandom) : sync_at(i));
    for (int i = 0; i < HDR_TAIL; i++) h[i] = 8'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 8) begin
      lim = int'(max_len);
      if (lim < HDR_LEN) begin
        len = $urandom_range(HDR_LEN, 60);
      end else begin
        case ($urandom_range(0, 7))
          0: len = (lim <= 400) ? lim : HDR_LEN;
          1: len = lim + 1;
          2: len = $urandom_range(0, HDR_LEN - 1);
          3: len = $urandom_range(HDR_LEN, (lim < 400) ? lim : 400);
          default: len = $urandom_range(HDR_LEN, (lim < 48) ? lim : 48);
        endcase
      end
      p = 0;
      repeat ($urandom_range(0, 4)) begin
        h[p] = pick_filler();
        p++;
      end
      if (mode == 7) begin
        h[p] = CH_MINUS;
        p++;
      end
      repeat ($urandom_range(0, 2)) begin
        h[p] = CH_ZERO;
        p++;
      end
      digits = $sformatf("%0d", len);
      for (int i = 0; i < digits.len(); i++) begin
        h[p] = digits[i];
        p++;
      end
      case ($urandom_range(0, 2))
        0: h[p] = CH_NUL;
        1: h[p] = CH_MINUS;
        default: h[p] = pick_filler();
      endcase
    end else begin
      for (int i = 0; i < HDR_TAIL; i++)
        case ($urandom_range(0, 4))
          0: h[i] = CH_ZERO + 8'($urandom_range(0, 9));
          1: h[i] = CH_MINUS;
          2: h[i] = CH_NUL;
          3: h[i] = 8'hFF;
          default: h[i] = 8'($urandom);
        endcase
    end
    for (int i = 0; i < HDR_TAIL; i++) send_byte(h[i]);
    while (framing) send_byte(8'($urandom));
  endtask

  task automatic run_random(input int unsigned n_busy);
    int unsigned stop_at;
    stop_at = busy_bytes + n_busy;
    while (busy_bytes < stop_at) send_random_frame();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    max_len = MAX_LEN_RESET;
    hunt_cnt = 0;
    hdr_check_armed = 1'b0;
    hdr_check_eof = 1'b0;
    hdr_check_abort = 1'b0;
    idling_on = 1'b1;
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_CASES; r++) begin
      for (int i = 0; i < 8; i++) send_byte(HDR_CASES[r].lead[63 - 8 * i -: 8]);
      for (int i = 0; i < SYNC_LEN; i++) send_byte(sync_at(i));
      for (int i = 0; i < HDR_TAIL; i++) begin
        if (i == HDR_TAIL - 1 && HDR_CASES[r].typed) begin
          hdr_check_armed = 1'b1;
          hdr_check_eof = HDR_CASES[r].t_eof;
          hdr_check_abort = HDR_CASES[r].t_abort;
        end
        send_byte(HDR_CASES[r].hdr[127 - 8 * i -: 8]);
      end
      while (framing) send_byte(8'($urandom));
    end

    set_max_len(16'd24);
    run_random(15);
    set_max_len(16'hFFFF);
    run_random(25);
    set_max_len(16'd0);
    run_random(15);
    set_max_len(16'($urandom_range(25, 300)));
    run_random(25);
    set_max_len(16'($urandom_range(24, 64)));
    idling_on = 1'b0;
    run_random(30);
    settle();

    $display("checked %0d output words from %0d input bytes: %0d frames closed, %0d aborted",
             words_seen, bytes_in, frames_done, frames_aborted);
    $display("length limits 1024, 24, 65535, 0 and two random values, with and without stalls");
    if (mismatches == 0) begin
      $display("PASS signature_length_deframer");
    end else begin
      $display("FAIL signature_length_deframer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sld_pkg.sv
src/sld_front.sv
src/sld_queue.sv
src/sld_back.sv
src/signature_length_deframer.sv
tb/tb_top.sv
